@@ src/bdu_pkg.sv @@
// ============================================================================
// bdu_pkg
// Shared types, codes and pixel arithmetic for the 2x bilinear upscaler.
// ============================================================================
package bdu_pkg;

   // Fixed field widths
   localparam int COORD_BITS    = 11;
   localparam int CFG_BITS      = 11;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int NUM_SLOTS     = 9;

   // Input transaction payload
   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
   } req_data_type;

   // Output transaction payload
   typedef struct packed {
      logic [COORD_BITS-1:0] out_row;
      logic [COORD_BITS-1:0] out_col;
      logic [7:0]            out_red;
      logic [7:0]            out_green;
      logic [7:0]            out_blue;
      logic                  last_of_run;
      logic                  frame_done;
   } rsp_data_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   // Register indexes (byte address bit 2)
   typedef enum logic {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

   // Result positions an input pixel can complete, in emission order
   typedef enum logic [3:0] {
      SLOT_ABOVE_LEFT  = 4'd0,
      SLOT_ABOVE       = 4'd1,
      SLOT_ABOVE_EDGE  = 4'd2,
      SLOT_LEFT        = 4'd3,
      SLOT_CUR         = 4'd4,
      SLOT_EDGE        = 4'd5,
      SLOT_BOTTOM_LEFT = 4'd6,
      SLOT_BOTTOM      = 4'd7,
      SLOT_BOTTOM_EDGE = 4'd8
   } slot_type;

   // One input pixel with its neighbors and precomputed coordinates
   typedef struct packed {
      pixel_type             cur;
      pixel_type             left;
      pixel_type             up;
      logic [COORD_BITS-1:0] row2;
      logic [COORD_BITS-1:0] col2;
      logic [COORD_BITS-1:0] row_edge;
      logic [COORD_BITS-1:0] col_edge;
      logic [NUM_SLOTS-1:0]  slots;
      logic                  last_row;
      logic                  last_col;
   } item_type;

   // Floored mean of two pixels, per channel
   function automatic pixel_type mean2(input pixel_type a, input pixel_type b);
      logic [8:0] sr;
      logic [8:0] sg;
      logic [8:0] sb;
      pixel_type  res;
      sr = {1'b0, a.red}   + {1'b0, b.red};
      sg = {1'b0, a.green} + {1'b0, b.green};
      sb = {1'b0, a.blue}  + {1'b0, b.blue};
      res.red   = sr[8:1];
      res.green = sg[8:1];
      res.blue  = sb[8:1];
      return res;
   endfunction

   // Floored mean of four pixels, per channel
   function automatic pixel_type mean4(input pixel_type a, input pixel_type b,
                                       input pixel_type c, input pixel_type d);
      logic [9:0] sr;
      logic [9:0] sg;
      logic [9:0] sb;
      pixel_type  res;
      sr = {2'b0, a.red}   + {2'b0, b.red}   + {2'b0, c.red}   + {2'b0, d.red};
      sg = {2'b0, a.green} + {2'b0, b.green} + {2'b0, c.green} + {2'b0, d.green};
      sb = {2'b0, a.blue}  + {2'b0, b.blue}  + {2'b0, c.blue}  + {2'b0, d.blue};
      res.red   = sr[9:2];
      res.green = sg[9:2];
      res.blue  = sb[9:2];
      return res;
   endfunction

endpackage

@@ src/bdu_line.sv @@
// ============================================================================
// bdu_line
// Input stage: raster counters, previous-row memory and the held pixel item.
// ============================================================================
module bdu_line #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  bdu_pkg::req_data_type          req_data,
   input  logic [bdu_pkg::CFG_BITS-1:0]   cfg_width,
   input  logic [bdu_pkg::CFG_BITS-1:0]   cfg_height,
   input  logic                           restart,
   output logic                           item_valid,
   output bdu_pkg::item_type              item,
   input  logic                           item_done
);

   localparam int CW = (MAX_WIDTH  > 2) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);

   logic [CW-1:0]          col_ff, col_in;
   logic [RW-1:0]          row_ff, row_in;
   logic                   item_vld_ff, item_vld_in;
   bdu_pkg::pixel_type     left_ff;
   bdu_pkg::pixel_type     mem_rd_ff;
   bdu_pkg::pixel_type     mem [MAX_WIDTH];
   bdu_pkg::item_type      hold_ff;
   bdu_pkg::item_type      hold_in;
   bdu_pkg::pixel_type     cur;
   logic [31:0]            w_full, h_full;
   logic [WW-1:0]          w_clamp;
   logic [HW-1:0]          h_clamp;
   logic                   accept;
   logic                   last_col, last_row;

   // Saturate the programmed size to 1..MAX
   always_comb begin
      if (cfg_width == '0) begin
         w_full = 32'd1;
      end else if (32'(cfg_width) > MAX_WIDTH) begin
         w_full = 32'(MAX_WIDTH);
      end else begin
         w_full = 32'(cfg_width);
      end
      if (cfg_height == '0) begin
         h_full = 32'd1;
      end else if (32'(cfg_height) > MAX_HEIGHT) begin
         h_full = 32'(MAX_HEIGHT);
      end else begin
         h_full = 32'(cfg_height);
      end
   end
   assign w_clamp = w_full[WW-1:0];
   assign h_clamp = h_full[HW-1:0];

   // Hold the input while the emitter still works on the held item
   assign req_stall = item_vld_ff & ~item_done;
   assign accept    = req_valid & ~req_stall;

   assign cur.red   = req_data.in_red;
   assign cur.green = req_data.in_green;
   assign cur.blue  = req_data.in_blue;

   assign last_col = (WW'(col_ff) == w_clamp - WW'(1));
   assign last_row = (HW'(row_ff) == h_clamp - HW'(1));

   // Advance the raster position and build the next item
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end

      hold_in          = hold_ff;
      hold_in.up       = mem_rd_ff;
      if (accept) begin
         hold_in.cur      = cur;
         hold_in.left     = left_ff;
         hold_in.row2     = bdu_pkg::COORD_BITS'({row_ff, 1'b0});
         hold_in.col2     = bdu_pkg::COORD_BITS'({col_ff, 1'b0});
         hold_in.row_edge = bdu_pkg::COORD_BITS'({h_clamp, 1'b0} - (HW+1)'(1));
         hold_in.col_edge = bdu_pkg::COORD_BITS'({w_clamp, 1'b0} - (WW+1)'(1));
         hold_in.last_row = last_row;
         hold_in.last_col = last_col;
         hold_in.slots    = '0;
         hold_in.slots[bdu_pkg::SLOT_ABOVE_LEFT]  = (row_ff != '0) && (col_ff != '0);
         hold_in.slots[bdu_pkg::SLOT_ABOVE]       = (row_ff != '0);
         hold_in.slots[bdu_pkg::SLOT_ABOVE_EDGE]  = (row_ff != '0) && last_col;
         hold_in.slots[bdu_pkg::SLOT_LEFT]        = (col_ff != '0);
         hold_in.slots[bdu_pkg::SLOT_CUR]         = 1'b1;
         hold_in.slots[bdu_pkg::SLOT_EDGE]        = last_col;
         hold_in.slots[bdu_pkg::SLOT_BOTTOM_LEFT] = last_row && (col_ff != '0);
         hold_in.slots[bdu_pkg::SLOT_BOTTOM]      = last_row;
         hold_in.slots[bdu_pkg::SLOT_BOTTOM_EDGE] = last_row && last_col;
      end

      if (accept) begin
         item_vld_in = 1'b1;
      end else if (item_done) begin
         item_vld_in = 1'b0;
      end else begin
         item_vld_in = item_vld_ff;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         item_vld_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         item_vld_ff <= item_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      if (accept) begin
         left_ff <= cur;
      end
   end

   // Previous-row memory: read the pixel above, then replace it with this one
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff   <= mem[col_ff];
         mem[col_ff] <= cur;
      end
   end

   assign item_valid = item_vld_ff;
   always_comb begin
      item    = hold_ff;
      item.up = mem_rd_ff;
   end

   // Column stays inside the programmed width
   assert property (@(posedge clock) disable iff (reset)
      WW'(col_ff) < w_clamp)
      else $error("column counter beyond image width");

   // Row stays inside the programmed height
   assert property (@(posedge clock) disable iff (reset)
      HW'(row_ff) < h_clamp)
      else $error("row counter beyond image height");

   // A held item always carries its own pixel result
   assert property (@(posedge clock) disable iff (reset)
      item_vld_ff |-> hold_ff.slots[bdu_pkg::SLOT_CUR])
      else $error("held item without its center result");

endmodule

@@ src/bdu_emit.sv @@
// ============================================================================
// bdu_emit
// Result sequencer: walks the held item's results and feeds the output register.
// ============================================================================
module bdu_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  bdu_pkg::item_type      item,
   output logic                   item_done,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output bdu_pkg::rsp_data_type  rsp_data
);

   logic [bdu_pkg::NUM_SLOTS-1:0]  sent_ff, sent_in;
   logic [bdu_pkg::NUM_SLOTS-1:0]  rem, pick;
   logic                           o_vld_ff, o_vld_in;
   bdu_pkg::rsp_data_type          o_data_ff;
   bdu_pkg::rsp_data_type          o_data_in;
   bdu_pkg::pixel_type             ul_ff;
   bdu_pkg::pixel_type             px;
   bdu_pkg::slot_type              sel;
   logic [bdu_pkg::COORD_BITS-1:0] row_m1, col_m1, orow, ocol;
   logic                           last, o_load;

   // Pick the lowest result still owed by the held item
   assign rem = item.slots & ~sent_ff;
   always_comb begin
      sel = bdu_pkg::SLOT_CUR;
      for (int i = bdu_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
         if (rem[i]) begin
            sel = bdu_pkg::slot_type'(4'(i));
         end
      end
   end
   assign pick = bdu_pkg::NUM_SLOTS'(1) << sel;
   assign last = ((rem & ~pick) == '0);

   assign o_load    = item_valid & (~o_vld_ff | ~rsp_stall);
   assign item_done = o_load & last;

   assign row_m1 = item.row2 - bdu_pkg::COORD_BITS'(1);
   assign col_m1 = item.col2 - bdu_pkg::COORD_BITS'(1);

   // Position and value of the selected result
   always_comb begin
      px   = '0;
      orow = item.row2;
      ocol = item.col2;
      case (sel)
         bdu_pkg::SLOT_ABOVE_LEFT: begin
            orow = row_m1;
            ocol = col_m1;
            px   = bdu_pkg::mean4(ul_ff, item.up, item.left, item.cur);
         end
         bdu_pkg::SLOT_ABOVE: begin
            orow = row_m1;
            px   = bdu_pkg::mean2(item.up, item.cur);
         end
         bdu_pkg::SLOT_ABOVE_EDGE: begin
            orow = row_m1;
            ocol = item.col_edge;
         end
         bdu_pkg::SLOT_LEFT: begin
            ocol = col_m1;
            px   = bdu_pkg::mean2(item.left, item.cur);
         end
         bdu_pkg::SLOT_CUR: begin
            px = item.cur;
         end
         bdu_pkg::SLOT_EDGE: begin
            ocol = item.col_edge;
         end
         bdu_pkg::SLOT_BOTTOM_LEFT: begin
            orow = item.row_edge;
            ocol = col_m1;
         end
         bdu_pkg::SLOT_BOTTOM: begin
            orow = item.row_edge;
         end
         bdu_pkg::SLOT_BOTTOM_EDGE: begin
            orow = item.row_edge;
            ocol = item.col_edge;
         end
         default: begin
            px = '0;
         end
      endcase

      o_data_in.out_row     = orow;
      o_data_in.out_col     = ocol;
      o_data_in.out_red     = px.red;
      o_data_in.out_green   = px.green;
      o_data_in.out_blue    = px.blue;
      o_data_in.last_of_run = last;
      o_data_in.frame_done  = last & item.last_row & item.last_col;
   end

   // Track sent results and the output register occupancy
   always_comb begin
      if (item_done) begin
         sent_in = '0;
      end else if (o_load) begin
         sent_in = sent_ff | pick;
      end else begin
         sent_in = sent_ff;
      end
      if (o_load) begin
         o_vld_in = 1'b1;
      end else if (~rsp_stall) begin
         o_vld_in = 1'b0;
      end else begin
         o_vld_in = o_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff  <= '0;
         o_vld_ff <= 1'b0;
      end else begin
         sent_ff  <= sent_in;
         o_vld_ff <= o_vld_in;
      end
   end

   // Output data and the upper-left neighbor for the next item
   always_ff @(posedge clock) begin
      if (o_load) begin
         o_data_ff <= o_data_in;
      end
      if (item_done) begin
         ul_ff <= item.up;
      end
   end

   assign rsp_valid = o_vld_ff;
   assign rsp_data  = o_data_ff;

   // Sent marks only cover results the held item owns
   assert property (@(posedge clock) disable iff (reset)
      item_valid |-> ((sent_ff & ~item.slots) == '0))
      else $error("sent mask outside item result set");

   // Finishing an item clears the sent marks
   assert property (@(posedge clock) disable iff (reset)
      item_done |=> (sent_ff == '0))
      else $error("sent mask not cleared after item");

   // Frame end is only flagged on a run end
   assert property (@(posedge clock) disable iff (reset)
      (o_vld_ff && o_data_ff.frame_done) |-> o_data_ff.last_of_run)
      else $error("frame end without run end");

endmodule

@@ src/bilinear_double_upscale.sv @@
// ============================================================================
// bilinear_double_upscale
// 2x bilinear enlargement of an RGB image streamed in raster order.
// ============================================================================
// Each accepted input pixel produces between one and nine output transactions
// (four for an interior pixel, fewer along row zero and column zero, more on
// the last column and last row), issued one per cycle from the output register
// while rsp_stall is low; a frame averages four results per input pixel.
// The result sequencer is the limiting unit; the next pixel is taken in the
// same cycle the previous pixel's last result is loaded. The previous input
// row sits in a single-port memory of MAX_WIDTH entries, read and rewritten in
// the cycle a pixel is accepted. It needs no clearing pass after reset: row
// zero of a frame never uses the value it reads. Writing either size register
// restarts the frame; sizes saturate to 1..MAX_WIDTH and 1..MAX_HEIGHT.
// ============================================================================
module bilinear_double_upscale #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bdu_pkg::req_data_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bdu_pkg::rsp_data_type               rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bdu_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [bdu_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [bdu_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   logic [bdu_pkg::CFG_BITS-1:0] width_ff, width_in;
   logic [bdu_pkg::CFG_BITS-1:0] height_ff, height_in;
   logic                         cfg_wr;
   bdu_pkg::reg_index_type       cfg_idx;
   logic                         item_valid, item_done;
   bdu_pkg::item_type            item;

   // Register file
   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg_idx    = bdu_pkg::reg_index_type'(csr_paddr[2]);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_wr) begin
         case (cfg_idx)
            bdu_pkg::REG_IMAGE_WIDTH:  width_in  = csr_pwdata[bdu_pkg::CFG_BITS-1:0];
            bdu_pkg::REG_IMAGE_HEIGHT: height_in = csr_pwdata[bdu_pkg::CFG_BITS-1:0];
            default:                   width_in  = width_ff;
         endcase
      end
      case (cfg_idx)
         bdu_pkg::REG_IMAGE_WIDTH:  csr_prdata = bdu_pkg::CSR_DATA_BITS'(width_ff);
         bdu_pkg::REG_IMAGE_HEIGHT: csr_prdata = bdu_pkg::CSR_DATA_BITS'(height_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bdu_pkg::CFG_BITS'(640);
         height_ff <= bdu_pkg::CFG_BITS'(480);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // Input stage with the row memory
   bdu_line #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_line (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .restart    (cfg_wr),
      .item_valid (item_valid),
      .item       (item),
      .item_done  (item_done)
   );

   // Result sequencer and output register
   bdu_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_done  (item_done),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

@@ tb/tb_bilinear_double_upscale.sv @@
// ============================================================================
// tb_bilinear_double_upscale
// Regression for the 2x bilinear upscaler.
// ============================================================================
// Pixels go in through the req_ channel. Every accepted pixel is run through
// a local model of the upscaler, and that model queues the output pixels the
// pixel completes. Each accepted rsp_ transaction is compared field by field
// with the oldest queued output pixel. Frame sizes are written through the
// csr_ port only while the block is drained, and each write is read back.
// The directed tests cover the reset size, one-pixel and two-by-two frames,
// a restart in the middle of a frame and out-of-range sizes. Random frames
// then run under four idle and stall mixes, followed by a long output
// hold-off that fills the block.
// ============================================================================
module tb_bilinear_double_upscale;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM     = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 4;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   bdu_pkg::req_data_type             req_data = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   bdu_pkg::rsp_data_type             rsp_data;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [bdu_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [bdu_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [bdu_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   // Local copy of the upscaler state and sizes
   logic [bdu_pkg::CFG_BITS-1:0] width_cfg = bdu_pkg::CFG_BITS'(640);
   logic [bdu_pkg::CFG_BITS-1:0] height_cfg = bdu_pkg::CFG_BITS'(480);
   bdu_pkg::req_data_type        line_buf [MAX_DIM];
   bdu_pkg::req_data_type        left_px = '0;
   bdu_pkg::req_data_type        upper_left_px = '0;
   int unsigned                  row_cnt = 0;
   int unsigned                  col_cnt = 0;

   bdu_pkg::rsp_data_type        upscaled_q [$];
   int                           error_count = 0;
   int                           cycle_count = 0;
   int                           send_idle_pct = 0;
   int                           rsp_stall_pct = 0;
   int                           rsp_hold_left = 0;

   bilinear_double_upscale u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bilinear_double_upscale regression: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Pixel arithmetic of the local model
   // ------------------------------------------------------------------------
   function automatic int eff_dim(input logic [bdu_pkg::CFG_BITS-1:0] v);
      if (v == 0) return 1;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
   endfunction

   function automatic logic [7:0] chan_avg2(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[8:1];
   endfunction

   function automatic logic [7:0] chan_avg4(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c, input logic [7:0] d);
      logic [9:0] s;
      s = {2'b0, a} + {2'b0, b} + {2'b0, c} + {2'b0, d};
      return s[9:2];
   endfunction

   function automatic bdu_pkg::req_data_type avg2(input bdu_pkg::req_data_type a,
                                                  input bdu_pkg::req_data_type b);
      bdu_pkg::req_data_type m;
      m.in_red   = chan_avg2(a.in_red, b.in_red);
      m.in_green = chan_avg2(a.in_green, b.in_green);
      m.in_blue  = chan_avg2(a.in_blue, b.in_blue);
      return m;
   endfunction

   function automatic bdu_pkg::req_data_type avg4(input bdu_pkg::req_data_type a,
                                                  input bdu_pkg::req_data_type b,
                                                  input bdu_pkg::req_data_type c,
                                                  input bdu_pkg::req_data_type d);
      bdu_pkg::req_data_type m;
      m.in_red   = chan_avg4(a.in_red, b.in_red, c.in_red, d.in_red);
      m.in_green = chan_avg4(a.in_green, b.in_green, c.in_green, d.in_green);
      m.in_blue  = chan_avg4(a.in_blue, b.in_blue, c.in_blue, d.in_blue);
      return m;
   endfunction

   function automatic bdu_pkg::rsp_data_type out_pixel(input int row, input int col,
                                                       input bdu_pkg::req_data_type p);
      bdu_pkg::rsp_data_type o;
      o.out_row     = row[bdu_pkg::COORD_BITS-1:0];
      o.out_col     = col[bdu_pkg::COORD_BITS-1:0];
      o.out_red     = p.in_red;
      o.out_green   = p.in_green;
      o.out_blue    = p.in_blue;
      o.last_of_run = 1'b0;
      o.frame_done  = 1'b0;
      return o;
   endfunction

   // Queue the output pixels completed by one accepted input pixel
   task automatic predict_upscale(input bdu_pkg::req_data_type px);
      int unsigned           w, h, r, c;
      bit                    at_last_col, at_last_row;
      bdu_pkg::req_data_type above;
      bdu_pkg::rsp_data_type outs [$];
      bdu_pkg::rsp_data_type tail;
      w = eff_dim(width_cfg);
      h = eff_dim(height_cfg);
      if (col_cnt >= w) col_cnt = 0;
      if (row_cnt >= h) row_cnt = 0;
      r = row_cnt;
      c = col_cnt;
      at_last_col = (c == w - 1);
      at_last_row = (r == h - 1);
      above = (r > 0) ? line_buf[c] : '0;
      // odd row above the current one
      if (r > 0) begin
         if (c > 0)
            outs.push_back(out_pixel(2*r-1, 2*c-1, avg4(upper_left_px, above, left_px, px)));
         outs.push_back(out_pixel(2*r-1, 2*c, avg2(above, px)));
         if (at_last_col) outs.push_back(out_pixel(2*r-1, 2*w-1, '0));
      end
      // even row of the current pixel
      if (c > 0) outs.push_back(out_pixel(2*r, 2*c-1, avg2(left_px, px)));
      outs.push_back(out_pixel(2*r, 2*c, px));
      if (at_last_col) outs.push_back(out_pixel(2*r, 2*w-1, '0));
      // zero bottom row of the doubled image
      if (at_last_row) begin
         if (c > 0) outs.push_back(out_pixel(2*h-1, 2*c-1, '0));
         outs.push_back(out_pixel(2*h-1, 2*c, '0));
         if (at_last_col) outs.push_back(out_pixel(2*h-1, 2*w-1, '0));
      end
      tail = outs.pop_back();
      tail.last_of_run = 1'b1;
      tail.frame_done  = at_last_row && at_last_col;
      outs.push_back(tail);
      foreach (outs[i]) upscaled_q.push_back(outs[i]);
      // advance the raster position
      upper_left_px = above;
      line_buf[c]   = px;
      left_px       = px;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_cnt = c;
      row_cnt = r;
   endtask

   // ------------------------------------------------------------------------
   // Result side: stall, hold off and check
   // ------------------------------------------------------------------------
   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : result_check
      bdu_pkg::rsp_data_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (upscaled_q.size() == 0) begin
               $error("unexpected output pixel at row %0d col %0d",
                      rsp_data.out_row, rsp_data.out_col);
               error_count++;
            end else begin
               want = upscaled_q.pop_front();
               check_field("out_row", want.out_row, rsp_data.out_row);
               check_field("out_col", want.out_col, rsp_data.out_col);
               check_field("out_red", want.out_red, rsp_data.out_red);
               check_field("out_green", want.out_green, rsp_data.out_green);
               check_field("out_blue", want.out_blue, rsp_data.out_blue);
               check_field("last_of_run", want.last_of_run, rsp_data.last_of_run);
               check_field("frame_done", want.frame_done, rsp_data.frame_done);
            end
         end
         // long hold-off first, then random stalls
         if (rsp_hold_left > 0) begin
            rsp_stall <= 1'b1;
            rsp_hold_left <= rsp_hold_left - 1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   // Offer one pixel, with random idle cycles in front, until accepted
   task automatic send_pixel(input bdu_pkg::req_data_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
      predict_upscale(px);
   endtask

   function automatic bdu_pkg::req_data_type rand_pixel();
      bdu_pkg::req_data_type p;
      p = bdu_pkg::req_data_type'(24'($urandom));
      if ($urandom_range(7) == 0) p.in_red = 8'hff;
      if ($urandom_range(7) == 0) p.in_green = 8'h00;
      if ($urandom_range(7) == 0) p.in_blue = 8'hff;
      return p;
   endfunction

   // Stop offering and wait for every queued output pixel
   task automatic wait_drain();
      req_valid <= 1'b0;
      while (upscaled_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write one size register, then read it back
   task automatic write_size(input bdu_pkg::reg_index_type idx,
                             input logic [bdu_pkg::CFG_BITS-1:0] value);
      logic [bdu_pkg::CSR_DATA_BITS-1:0] rd;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= bdu_pkg::CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= bdu_pkg::CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      // register and frame restart take effect at this edge
      if (idx == bdu_pkg::REG_IMAGE_WIDTH) width_cfg = value;
      else height_cfg = value;
      row_cnt = 0;
      col_cnt = 0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rd = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd[bdu_pkg::CFG_BITS-1:0] !== value) begin
         $error("readback %s: expected %0d, got %0d", idx.name(), value,
                rd[bdu_pkg::CFG_BITS-1:0]);
         error_count++;
      end
   endtask

   task automatic set_frame_size(input logic [bdu_pkg::CFG_BITS-1:0] w,
                                 input logic [bdu_pkg::CFG_BITS-1:0] h);
      wait_drain();
      write_size(bdu_pkg::REG_IMAGE_WIDTH, w);
      write_size(bdu_pkg::REG_IMAGE_HEIGHT, h);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Start of a 640x480 frame with the sizes left at reset
   task automatic test_reset_size();
      send_pixel(24'h000000);
      send_pixel(24'hffffff);
      send_pixel(24'hff00ff);
      send_pixel(24'h00ff00);
      send_pixel(24'h010101);
   endtask

   // One-pixel frames, a full 2x2 frame and a restart in mid frame
   task automatic test_small_frames();
      // zero sizes saturate to a single pixel
      set_frame_size(0, 0);
      send_pixel(24'h12fe80);
      send_pixel(24'hff0001);
      set_frame_size(2, 2);
      send_pixel(24'hffffff);
      send_pixel(24'h000000);
      send_pixel(24'h010101);
      send_pixel(24'hfefefe);
      send_pixel(24'h7f807f);
      // rewriting a size drops the partial frame
      set_frame_size(3, 2);
      send_pixel(24'h102030);
      send_pixel(24'hf0e0d0);
      wait_drain();
      write_size(bdu_pkg::REG_IMAGE_HEIGHT, 2);
      repeat (6) send_pixel(rand_pixel());
   endtask

   // Sizes above the maximum saturate
   task automatic test_size_limits();
      set_frame_size(2047, 1);
      send_pixel(24'hffffff);
      send_pixel(24'h000000);
      set_frame_size(1, 2047);
      send_pixel(24'haa55aa);
      send_pixel(24'h55aa55);
      set_frame_size(1024, 1024);
      send_pixel(24'h808080);
   endtask

   // Mostly complete random frames, some cut short
   task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                     input int budget);
      int sent, n, frame;
      logic [bdu_pkg::CFG_BITS-1:0] w, h;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < budget) begin
         w = bdu_pkg::CFG_BITS'(($urandom_range(15) == 0) ? 0 :
                 ($urandom_range(7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6));
         h = bdu_pkg::CFG_BITS'(($urandom_range(15) == 0) ? 0 :
                 ($urandom_range(7) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6));
         set_frame_size(w, h);
         frame = eff_dim(w) * eff_dim(h);
         if ($urandom_range(4) == 0) n = $urandom_range(1, frame);
         else n = frame * $urandom_range(1, 2);
         if (n > budget - sent) n = budget - sent;
         repeat (n) send_pixel(rand_pixel());
         sent += n;
      end
   endtask

   // Output held off long enough to fill the block and stall the input
   task automatic test_output_holdoff();
      set_frame_size(4, 3);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 300;
      repeat (24) send_pixel(rand_pixel());
      wait_drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_size();
      test_small_frames();
      test_size_limits();
      test_random_frames(0, 0, 75);
      test_random_frames(47, 0, 75);
      test_random_frames(0, 47, 75);
      test_random_frames(16, 16, 75);
      test_output_holdoff();
      wait_drain();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("bilinear_double_upscale regression: pass");
      end else begin
         $display("bilinear_double_upscale regression: fail");
      end
      $finish;
   end

endmodule
